// ===== sv/code_signature_matcher_assert.svh =====
// Assertion macros for the code signature matcher.
// Expects a clock named aclk and an active-low synchronous reset named aresetn.
`ifndef CODE_SIGNATURE_MATCHER_ASSERT_SVH
`define CODE_SIGNATURE_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/csm_pkg.sv =====
// Package for the code signature matcher: signature kinds, prefixes and needles.
// No dependencies.
`timescale 1ns / 1ps

package csm_pkg;

    typedef enum logic [1:0] {
        KIND_ADD_OUTPUT     = 2'd0,
        KIND_REMOVE_OUTPUT  = 2'd1,
        KIND_REGISTER_OBJ   = 2'd2,
        KIND_UNREGISTER_OBJ = 2'd3
    } kind_t;

    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_LIMIT = 5'd16;
    localparam logic [POS_W-1:0] NEEDLE_MIN_POS = 5'd4;

    localparam logic [7:0] PREFIX_A [16] = '{
        8'h48, 8'h89, 8'h74, 8'h24, 8'h20, 8'h41, 8'h54, 8'h41,
        8'h56, 8'h41, 8'h57, 8'h48, 8'h83, 8'hEC, 8'h20, 8'h41
    };
    localparam logic [7:0] PREFIX_B [9] = '{
        8'h40, 8'h53, 8'h48, 8'h83, 8'hEC, 8'h20, 8'h48, 8'h8B, 8'hD9
    };
    localparam logic [7:0] PREFIX_C [13] = '{
        8'h40, 8'h53, 8'h48, 8'h83, 8'hEC, 8'h20, 8'h48, 8'h8B, 8'hD9,
        8'h48, 8'h83, 8'hF9, 8'hE0
    };

    localparam logic [POS_W-1:0] PREFIX_A_LEN = 5'd16;
    localparam logic [POS_W-1:0] PREFIX_B_LEN = 5'd9;
    localparam logic [POS_W-1:0] PREFIX_C_LEN = 5'd13;

    // Needles are held oldest byte first, in the high bits.
    localparam logic [39:0] NEEDLE_ADD   = 40'hBA_1C_00_00_00;
    localparam logic [39:0] NEEDLE_REM   = 40'hBA_1D_00_00_00;
    localparam logic [39:0] NEEDLE_REG   = 40'hBA_0B_00_00_00;
    localparam logic [39:0] NEEDLE_UNREG = 40'hBA_0C_00_00_00;

    function automatic logic [POS_W-1:0] prefix_len(input kind_t kind);
        logic [POS_W-1:0] len;
        unique case (kind)
            KIND_ADD_OUTPUT:    len = PREFIX_A_LEN;
            KIND_REMOVE_OUTPUT: len = PREFIX_B_LEN;
            default:            len = PREFIX_C_LEN;
        endcase
        return len;
    endfunction

    // Only meaningful while pos is below the prefix length of the kind.
    function automatic logic [7:0] prefix_byte(input kind_t kind, input logic [3:0] pos);
        logic [7:0] pb;
        unique case (kind)
            KIND_ADD_OUTPUT:    pb = PREFIX_A[pos];
            KIND_REMOVE_OUTPUT: pb = (pos < 4'd9) ? PREFIX_B[pos] : PREFIX_B[0];
            default:            pb = (pos < 4'd13) ? PREFIX_C[pos] : PREFIX_C[0];
        endcase
        return pb;
    endfunction

    function automatic logic [39:0] needle(input kind_t kind);
        logic [39:0] nd;
        unique case (kind)
            KIND_ADD_OUTPUT:     nd = NEEDLE_ADD;
            KIND_REMOVE_OUTPUT:  nd = NEEDLE_REM;
            KIND_REGISTER_OBJ:   nd = NEEDLE_REG;
            KIND_UNREGISTER_OBJ: nd = NEEDLE_UNREG;
            default:             nd = NEEDLE_ADD;
        endcase
        return nd;
    endfunction

endpackage

// ===== sv/code_signature_matcher.sv =====
// The match bit of a span is registered and valid in the cycle after its last word is accepted.
// Throughput: one code byte per cycle while s_ready is high; the result register drains while bytes flow.
// s_ready drops only while a finished result waits in the result register.
// Reset (aresetn low, synchronous) clears the span state, the result register and
// selects the add-output signature kind. The end of each span clears the span state.
`timescale 1ns / 1ps

// Top level of the code signature matcher; uses csm_pkg and the assertion header.
// Prefix check, needle search and result register all live here.
`include "code_signature_matcher_assert.svh"

module code_signature_matcher (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_code_byte,
    input  logic       s_last_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_signature_match
);

    csm_pkg::kind_t                kind_reg;
    logic [csm_pkg::POS_W-1:0]     byte_position_reg, byte_position_next;
    logic                          prefix_good_reg, prefix_good_next;
    logic [31:0]                   previous_bytes_reg, previous_bytes_next;
    logic                          needle_seen_reg, needle_seen_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          match_reg, match_next;

    logic                          s_accept;
    logic [csm_pkg::POS_W-1:0]     plen;
    logic [39:0]                   needle_word;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    assign m_valid           = m_valid_reg;
    assign m_signature_match = match_reg;

    assign plen        = csm_pkg::prefix_len(kind_reg);
    assign needle_word = csm_pkg::needle(kind_reg);

    always_comb begin
        byte_position_next  = byte_position_reg;
        prefix_good_next    = prefix_good_reg;
        previous_bytes_next = previous_bytes_reg;
        needle_seen_next    = needle_seen_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        match_next          = match_reg;

        if (s_accept) begin
            if (byte_position_reg < plen &&
                s_code_byte != csm_pkg::prefix_byte(kind_reg, byte_position_reg[3:0])) begin
                prefix_good_next = 1'b0;
            end
            // The needle ends on this byte if the four bytes before it match too.
            if (byte_position_reg >= csm_pkg::NEEDLE_MIN_POS &&
                {previous_bytes_reg, s_code_byte} == needle_word) begin
                needle_seen_next = 1'b1;
            end
            previous_bytes_next = {previous_bytes_reg[23:0], s_code_byte};
            if (byte_position_reg < csm_pkg::POS_LIMIT) begin
                byte_position_next = byte_position_reg + 1'b1;
            end

            if (s_last_byte) begin
                m_valid_next        = 1'b1;
                match_next          = prefix_good_next && (byte_position_next >= plen) &&
                                      needle_seen_next;
                byte_position_next  = '0;
                prefix_good_next    = 1'b1;
                previous_bytes_next = '0;
                needle_seen_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg           <= csm_pkg::KIND_ADD_OUTPUT;
            byte_position_reg  <= '0;
            prefix_good_reg    <= 1'b1;
            previous_bytes_reg <= '0;
            needle_seen_reg    <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                kind_reg <= csm_pkg::kind_t'(cfg_data);
            end
            byte_position_reg  <= byte_position_next;
            prefix_good_reg    <= prefix_good_next;
            previous_bytes_reg <= previous_bytes_next;
            needle_seen_reg    <= needle_seen_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    `CSM_ASSERT_SAME(a_pos_saturates, 1'b1, byte_position_reg <= csm_pkg::POS_LIMIT,
        "byte position ran past its limit")
    `CSM_ASSERT_NEXT(a_last_clears_span, s_accept && s_last_byte,
        m_valid_reg && byte_position_reg == '0 && prefix_good_reg && !needle_seen_reg,
        "end of span did not post a result and clear the span state")
    `CSM_ASSERT_NEXT(a_pos_counts, s_accept && !s_last_byte &&
        byte_position_reg < csm_pkg::POS_LIMIT,
        byte_position_reg == $past(byte_position_reg) + 1'b1,
        "byte position did not advance on an accepted word")
    `CSM_ASSERT_SAME(a_fail_needs_bytes, !prefix_good_reg || needle_seen_reg,
        byte_position_reg != '0, "span flags set with no byte taken")

endmodule

// ===== sim/code_signature_matcher_tb.sv =====
// Self-checking testbench for code_signature_matcher: a directed table of code spans,
// then random spans under three idling mixes, each result checked against a predictor or a pinned value.
// Depends on csm_pkg for the signature kind enum and on the matcher RTL.
`timescale 1ns / 1ps

module code_signature_matcher_tb;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'b00;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_code_byte = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_signature_match;

    // Testbench-side tag that travels with each input word of the directed table.
    logic       table_pin = 1'b0;
    logic       table_match = 1'b0;

    int             src_idle_pct = 0;
    int             sink_idle_pct = 0;
    int             bytes_sent = 0;
    int             mismatches = 0;
    csm_pkg::kind_t next_kind = csm_pkg::KIND_ADD_OUTPUT;

    // Predictor state.
    csm_pkg::kind_t active_kind;
    logic [4:0]     seen_count;
    logic           lead_ok;
    logic [31:0]    recent;
    logic           needle_hit;
    logic           match_q[$];

    localparam logic [7:0] LEAD_A [16] = '{
        8'h48, 8'h89, 8'h74, 8'h24, 8'h20, 8'h41, 8'h54, 8'h41,
        8'h56, 8'h41, 8'h57, 8'h48, 8'h83, 8'hEC, 8'h20, 8'h41
    };
    // The remove-output prefix is the first nine bytes of this one.
    localparam logic [7:0] LEAD_C [13] = '{
        8'h40, 8'h53, 8'h48, 8'h83, 8'hEC, 8'h20, 8'h48, 8'h8B, 8'hD9,
        8'h48, 8'h83, 8'hF9, 8'hE0
    };
    localparam logic [7:0] NEEDLE_ID [4] = '{8'h1C, 8'h1D, 8'h0B, 8'h0C};

    typedef struct packed {
        csm_pkg::kind_t kind;
        logic [7:0]     code;
        logic           last;
        logic           pinned;
        logic           match;
    } stim_row_t;

    localparam stim_row_t DIRECTED [24] = '{
        '{csm_pkg::KIND_ADD_OUTPUT,     8'h00, 1'b1, 1'b1, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h40, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h53, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h48, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h83, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'hEC, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h20, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h48, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h8B, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'hD9, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'hBA, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h1D, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h00, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h00, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REMOVE_OUTPUT,  8'h00, 1'b1, 1'b1, 1'b1},
        '{csm_pkg::KIND_UNREGISTER_OBJ, 8'hFF, 1'b1, 1'b1, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'h40, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'h53, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'h48, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'h83, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'hEC, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'h20, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'h48, 1'b0, 1'b0, 1'b0},
        '{csm_pkg::KIND_REGISTER_OBJ,   8'h8B, 1'b1, 1'b1, 1'b0}
    };

    code_signature_matcher DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_code_byte       (s_code_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_signature_match (m_signature_match)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned lead_len(input csm_pkg::kind_t k);
        unique case (k)
            csm_pkg::KIND_ADD_OUTPUT:    return 16;
            csm_pkg::KIND_REMOVE_OUTPUT: return 9;
            default:                     return 13;
        endcase
    endfunction

    function automatic logic [7:0] lead_byte(input csm_pkg::kind_t k, input int unsigned i);
        return (k == csm_pkg::KIND_ADD_OUTPUT) ? LEAD_A[i] : LEAD_C[i];
    endfunction

    function automatic logic [39:0] call_needle(input csm_pkg::kind_t k);
        return {8'hBA, NEEDLE_ID[int'(k)], 24'h000000};
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_span();
        seen_count = 5'd0;
        lead_ok = 1'b1;
        recent = 32'h0;
        needle_hit = 1'b0;
    endtask

    task automatic track_byte(input logic [7:0] b, input logic fin, input logic pin,
                              input logic pin_val);
        logic verdict;
        if (seen_count < lead_len(active_kind) && b != lead_byte(active_kind, seen_count))
            lead_ok = 1'b0;
        if (seen_count >= 4 && {recent, b} == call_needle(active_kind))
            needle_hit = 1'b1;
        recent = {recent[23:0], b};
        if (seen_count < 5'd16)
            seen_count++;
        if (fin) begin
            verdict = lead_ok && seen_count >= lead_len(active_kind) && needle_hit;
            match_q.push_back(pin ? pin_val : verdict);
            clear_span();
        end
    endtask

    // Results are checked before the new word is taken in, so a result can never be
    // matched against an expectation pushed at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            active_kind = csm_pkg::KIND_ADD_OUTPUT;
            clear_span();
        end else begin
            if (m_valid && m_ready) begin
                if (match_q.size() == 0)
                    report_mismatch("result word with nothing expected");
                else if (m_signature_match !== match_q[0])
                    report_mismatch($sformatf("signature_match %b, expected %b",
                                              m_signature_match, match_q[0]));
                if (match_q.size() != 0)
                    void'(match_q.pop_front());
            end
            if (cfg_valid && cfg_ready)
                active_kind = csm_pkg::kind_t'(cfg_data);
            if (s_valid && s_ready)
                track_byte(s_code_byte, s_last_byte, table_pin, table_match);
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic push_byte(input logic [7:0] b, input logic fin, input logic pin = 1'b0,
                             input logic pin_val = 1'b0);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_code_byte <= b;
        s_last_byte <= fin;
        table_pin <= pin;
        table_match <= pin_val;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (match_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_kind(input csm_pkg::kind_t k);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= k;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        next_kind = k;
    endtask

    task automatic send_span();
        logic [7:0] span_q[$];
        logic [39:0] nd;
        int unsigned plen;
        int unsigned style;
        int unsigned pick;
        nd = call_needle(next_kind);
        plen = lead_len(next_kind);
        style = $urandom_range(99);
        if (style < 65) begin
            // A proper span: prefix, some filler, usually the needle, more filler.
            for (int unsigned i = 0; i < plen; i++)
                span_q.push_back(lead_byte(next_kind, i));
            if ($urandom_range(9) == 0) begin
                pick = $urandom_range(plen - 1);
                span_q[pick] = span_q[pick] ^ (8'h01 << $urandom_range(7));
            end
            repeat ($urandom_range(4)) span_q.push_back(8'($urandom));
            if ($urandom_range(9) < 7) begin
                for (int i = 4; i >= 0; i--)
                    span_q.push_back(nd[8*i +: 8]);
                if ($urandom_range(9) == 0) begin
                    pick = span_q.size() - 1 - $urandom_range(4);
                    span_q[pick] = span_q[pick] ^ (8'h01 << $urandom_range(7));
                end
            end
            repeat ($urandom_range(3)) span_q.push_back(8'($urandom));
        end else if (style < 80) begin
            pick = $urandom_range(plen - 1, 1);
            for (int unsigned i = 0; i < pick; i++)
                span_q.push_back(lead_byte(next_kind, i));
        end else if (style < 90) begin
            repeat ($urandom_range(12)) span_q.push_back(8'($urandom));
            for (int i = 4; i >= 0; i--)
                span_q.push_back(nd[8*i +: 8]);
            repeat ($urandom_range(12)) span_q.push_back(8'($urandom));
        end else begin
            // Long noise can also drive the position counter up to its ceiling, where it saturates.
            repeat ($urandom_range(40, 1)) span_q.push_back(8'($urandom));
        end
        foreach (span_q[i])
            push_byte(span_q[i], i == span_q.size() - 1);
    endtask

    initial begin
        int target;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 29;
        sink_idle_pct = 78;
        for (int r = 0; r < 24; r++) begin
            if (DIRECTED[r].kind != next_kind)
                write_kind(DIRECTED[r].kind);
            push_byte(DIRECTED[r].code, DIRECTED[r].last, DIRECTED[r].pinned,
                      DIRECTED[r].match);
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 78 : 0;
            sink_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 29 : 0;
            target = 1550 * (phase + 1) / 3;
            write_kind(csm_pkg::kind_t'($urandom_range(3)));
            while (bytes_sent < target) begin
                if ($urandom_range(3) == 0)
                    write_kind(csm_pkg::kind_t'($urandom_range(3)));
                send_span();
            end
        end

        wait_idle();
        repeat (5) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/csm_pkg.sv
sv/code_signature_matcher.sv
sim/code_signature_matcher_tb.sv
